### hdl/nfba_pkg.sv
// Shared codes and constants for the next-fit block allocator.
`default_nettype none

package nfba_pkg;

  // Request codes carried by in_mode
  typedef enum logic [1:0] {
    MODE_INIT  = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_FREE  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // Result codes carried by out_status
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_SPACE = 3'd1,
    ST_BAD_PTR  = 3'd2,
    ST_RANGE    = 3'd3,
    ST_OVERLAP  = 3'd4,
    ST_NOT_INIT = 3'd5
  } status_t;

  localparam logic [13:0] MIN_ARENA_BYTES = 14'd41;
  localparam logic [13:0] CTRL_BYTES      = 14'd16;
  localparam logic [13:0] PAYLOAD_BASE    = 14'd24;
  localparam logic [13:0] SMALL_REQ       = 14'd8;
  localparam logic [13:0] SMALL_ROUND     = 14'd15;
  localparam logic [13:0] ROUND_ADD       = 14'd7;
  localparam int unsigned MIN_SPAN        = 3;

endpackage

`default_nettype wire

### hdl/nfba_hdr_mem.sv
// Block header store: one write port, one registered read port.
`default_nettype none

module nfba_hdr_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 22
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write the addressed header
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/next_fit_block_allocator.sv
// Next-fit free-list allocator over an arena of 8-byte blocks, headers held in one RAM.
//
// One request is in flight at a time; in_ready is high while the sequencer is idle, and a
// finished result sits in the output register so the next request can be taken while it
// waits. The header RAM has one read port and one write port, with registered read data.
// Initialise writes the head block, then the end sentinel; allocate reads the rover and
// visits free-list nodes until one fits or the list wraps; free steps past free-list
// nodes while searching its sorted place. Requests settled in idle (not initialised, bad
// or out-of-range pointer, unknown mode) go to done. Initialise samples arena_bytes.
// Headers are not cleared after reset; an initialise lays out the list before use.
// The user writes arena_bytes through the cfg port while idle; the block does not check.
`default_nettype none

module next_fit_block_allocator #(
  parameter int ARENA_BLOCKS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [13:0] in_request_bytes,
  input  wire logic [13:0] in_free_address,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [13:0]      out_address,
  output logic [13:0]      out_free_bytes,
  // configuration write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [13:0] cfg_data
);

  import nfba_pkg::*;

  localparam int IW = (ARENA_BLOCKS > 1) ? $clog2(ARENA_BLOCKS) : 1;
  localparam int ZW = IW + 1;
  localparam int SW = IW + 2;
  localparam int CW = (IW + 3 > 15) ? IW + 3 : 15;

  typedef struct packed {
    logic [IW-1:0] nxt;
    logic [ZW-1:0] size;
    logic          alloc;
  } hdr_t;

  localparam int HW = $bits(hdr_t);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_INIT1 = 12'b0000_0000_0010,
    S_AROOT = 12'b0000_0000_0100,
    S_AWALK = 12'b0000_0000_1000,
    S_AWR   = 12'b0000_0001_0000,
    S_FHC   = 12'b0000_0010_0000,
    S_FADV  = 12'b0000_0100_0000,
    S_FLOOP = 12'b0000_1000_0000,
    S_FCHK  = 12'b0001_0000_0000,
    S_FNB   = 12'b0010_0000_0000,
    S_FWF   = 12'b0100_0000_0000,
    S_DONE  = 12'b1000_0000_0000
  } state_t;

  state_t        state_r, state_nxt;
  logic [13:0]   arena_bytes_r, arena_bytes_nxt;
  logic [ZW-1:0] span_r, span_nxt;
  logic [IW-1:0] rover_r, rover_nxt;
  logic [10:0]   used_r, used_nxt;
  logic          ready_r, ready_nxt;
  logic [CW-1:0] need_r, need_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [IW-1:0] prev_r, prev_nxt;
  hdr_t          prev_rec_r, prev_rec_nxt;
  logic [SW-1:0] steps_r, steps_nxt;
  logic [IW-1:0] cfin_r, cfin_nxt;
  logic [IW-1:0] c_r, c_nxt;
  hdr_t          hc_r, hc_nxt;
  logic [IW-1:0] f_r, f_nxt;
  hdr_t          hf_r, hf_nxt;
  logic          tail_r, tail_nxt;
  hdr_t          cnew_r, cnew_nxt;
  logic [2:0]    res_status_r, res_status_nxt;
  logic [13:0]   res_addr_r, res_addr_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_status_r, out_status_nxt;
  logic [13:0]   out_address_r, out_address_nxt;
  logic [13:0]   out_free_bytes_r, out_free_bytes_nxt;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  hdr_t          mem_wdata;
  logic [IW-1:0] mem_raddr;
  logic [HW-1:0] mem_rdata;
  hdr_t          rd;

  logic [CW-1:0] span_full;
  logic [CW-1:0] need_calc;
  logic [CW-1:0] c_full;
  logic [CW-1:0] rest;
  logic [CW-1:0] c_end;
  logic [CW-1:0] f_end;
  logic [CW-1:0] free_diff;
  logic [CW-1:0] addr_full;
  logic          nb_join;
  logic          adv;

  nfba_hdr_mem #(
    .DEPTH (ARENA_BLOCKS),
    .AW    (IW),
    .DW    (HW)
  ) u_hdr_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd        = hdr_t'(mem_rdata);
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_address    = out_address_r;
  assign out_free_bytes = out_free_bytes_r;

  // Derived quantities for the current request
  always_comb begin
    span_full = (CW'(arena_bytes_r) - CW'(CTRL_BYTES)) >> 3;
    if (span_full > CW'(ARENA_BLOCKS)) begin
      span_full = CW'(ARENA_BLOCKS);
    end
    if (in_request_bytes < SMALL_REQ) begin
      need_calc = (CW'(SMALL_ROUND) >> 3) + CW'(1);
    end else begin
      need_calc = ((CW'(in_request_bytes) + CW'(ROUND_ADD)) >> 3) + CW'(1);
    end
    c_full    = (CW'(in_free_address) - CW'(PAYLOAD_BASE)) >> 3;
    rest      = CW'(rd.size) - need_r;
    c_end     = CW'(c_r) + CW'(hc_r.size);
    f_end     = CW'(f_r) + CW'(hf_r.size);
    free_diff = CW'(span_r) - CW'(used_r) - CW'(1);
    addr_full = CW'(PAYLOAD_BASE) + (CW'(cfin_r) << 3);
    nb_join   = (c_end == CW'(hf_r.nxt)) && (rd.size != '0);
    adv       = (f_r < hf_r.nxt) || ((c_r >= hf_r.nxt) && (f_r >= c_r));
  end

  // Request sequencer
  always_comb begin
    state_nxt          = state_r;
    arena_bytes_nxt    = arena_bytes_r;
    span_nxt           = span_r;
    rover_nxt          = rover_r;
    used_nxt           = used_r;
    ready_nxt          = ready_r;
    need_nxt           = need_r;
    cur_nxt            = cur_r;
    prev_nxt           = prev_r;
    prev_rec_nxt       = prev_rec_r;
    steps_nxt          = steps_r;
    cfin_nxt           = cfin_r;
    c_nxt              = c_r;
    hc_nxt             = hc_r;
    f_nxt              = f_r;
    hf_nxt             = hf_r;
    tail_nxt           = tail_r;
    cnew_nxt           = cnew_r;
    res_status_nxt     = res_status_r;
    res_addr_nxt       = res_addr_r;
    out_valid_nxt      = out_valid_r;
    out_status_nxt     = out_status_r;
    out_address_nxt    = out_address_r;
    out_free_bytes_nxt = out_free_bytes_r;
    mem_we             = 1'b0;
    mem_waddr          = '0;
    mem_wdata          = '0;
    mem_raddr          = '0;

    // Take configuration writes
    if (cfg_valid) begin
      arena_bytes_nxt = cfg_data;
    end

    // Drop a result once it is taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_addr_nxt   = '0;
          res_status_nxt = ST_OK;
          state_nxt      = S_DONE;
          case (in_mode)
            MODE_INIT: begin
              if (arena_bytes_r < MIN_ARENA_BYTES) begin
                res_status_nxt = ST_NO_SPACE;
              end else begin
                // Lay out the head block, sentinel follows
                span_nxt        = ZW'(span_full);
                mem_we          = 1'b1;
                mem_waddr       = '0;
                mem_wdata.nxt   = IW'(span_full - CW'(1));
                mem_wdata.size  = ZW'(span_full - CW'(1));
                mem_wdata.alloc = 1'b0;
                state_nxt       = S_INIT1;
              end
            end
            MODE_ALLOC: begin
              if (!ready_r) begin
                res_status_nxt = ST_NOT_INIT;
              end else begin
                need_nxt  = need_calc;
                steps_nxt = '0;
                mem_raddr = rover_r;
                state_nxt = S_AROOT;
              end
            end
            MODE_FREE: begin
              if (!ready_r) begin
                res_status_nxt = ST_NOT_INIT;
              end else if (in_free_address == '0 || in_free_address[2:0] != 3'd0) begin
                res_status_nxt = ST_BAD_PTR;
              end else if (in_free_address < PAYLOAD_BASE) begin
                res_status_nxt = ST_RANGE;
              end else if (c_full >= CW'(span_r)) begin
                res_status_nxt = ST_RANGE;
              end else begin
                c_nxt     = IW'(c_full);
                mem_raddr = IW'(c_full);
                state_nxt = S_FHC;
              end
            end
            default: begin
              res_status_nxt = ST_OK;
            end
          endcase
        end
      end

      S_INIT1: begin
        // Write the zero-size end sentinel
        mem_we         = 1'b1;
        mem_waddr      = IW'(CW'(span_r) - CW'(1));
        mem_wdata      = '0;
        rover_nxt      = '0;
        used_nxt       = '0;
        ready_nxt      = 1'b1;
        res_status_nxt = ST_OK;
        state_nxt      = S_DONE;
      end

      S_AROOT: begin
        prev_nxt     = rover_r;
        prev_rec_nxt = rd;
        cur_nxt      = rd.nxt;
        mem_raddr    = rd.nxt;
        state_nxt    = S_AWALK;
      end

      S_AWALK: begin
        if (CW'(rd.size) >= need_r) begin
          if (rest == '0) begin
            // Exact fit: unlink from the predecessor
            mem_we          = 1'b1;
            mem_waddr       = prev_r;
            mem_wdata.nxt   = rd.nxt;
            mem_wdata.size  = prev_rec_r.size;
            mem_wdata.alloc = prev_rec_r.alloc;
            cfin_nxt        = cur_r;
          end else begin
            // Carve from the tail of the free block
            mem_we          = 1'b1;
            mem_waddr       = cur_r;
            mem_wdata.nxt   = rd.nxt;
            mem_wdata.size  = ZW'(rest);
            mem_wdata.alloc = rd.alloc;
            cfin_nxt        = IW'(CW'(cur_r) + rest);
          end
          rover_nxt = prev_r;
          used_nxt  = used_r + need_r[10:0];
          state_nxt = S_AWR;
        end else if (cur_r == rover_r || steps_r >= SW'(ARENA_BLOCKS)) begin
          res_status_nxt = ST_NO_SPACE;
          state_nxt      = S_DONE;
        end else begin
          // Advance to the next free block
          steps_nxt    = steps_r + SW'(1);
          prev_nxt     = cur_r;
          prev_rec_nxt = rd;
          cur_nxt      = rd.nxt;
          mem_raddr    = rd.nxt;
        end
      end

      S_AWR: begin
        mem_we          = 1'b1;
        mem_waddr       = cfin_r;
        mem_wdata.nxt   = '0;
        mem_wdata.size  = ZW'(need_r);
        mem_wdata.alloc = 1'b1;
        res_status_nxt  = ST_OK;
        res_addr_nxt    = addr_full[13:0];
        state_nxt       = S_DONE;
      end

      S_FHC: begin
        if (!rd.alloc || rd.size == '0) begin
          res_status_nxt = ST_BAD_PTR;
          state_nxt      = S_DONE;
        end else begin
          hc_nxt    = rd;
          f_nxt     = rover_r;
          steps_nxt = '0;
          mem_raddr = rover_r;
          state_nxt = S_FADV;
        end
      end

      S_FADV: begin
        hf_nxt = rd;
        if (f_r < c_r && c_r < rd.nxt) begin
          tail_nxt  = 1'b0;
          state_nxt = S_FCHK;
        end else begin
          state_nxt = S_FLOOP;
        end
      end

      S_FLOOP: begin
        if (c_r == f_r || steps_r >= SW'(ARENA_BLOCKS + 1)) begin
          res_status_nxt = ST_OVERLAP;
          state_nxt      = S_DONE;
        end else begin
          steps_nxt = steps_r + SW'(1);
          if (adv) begin
            f_nxt     = hf_r.nxt;
            mem_raddr = hf_r.nxt;
            state_nxt = S_FADV;
          end else begin
            // Wrap point: either before the first node or after the last
            tail_nxt  = (c_r >= hf_r.nxt);
            state_nxt = S_FCHK;
          end
        end
      end

      S_FCHK: begin
        if (!tail_r && CW'(hf_r.nxt) < c_end) begin
          res_status_nxt = ST_OVERLAP;
          state_nxt      = S_DONE;
        end else if (f_r < c_r && CW'(c_r) < f_end) begin
          res_status_nxt = ST_OVERLAP;
          state_nxt      = S_DONE;
        end else begin
          mem_raddr = IW'(c_end);
          state_nxt = S_FNB;
        end
      end

      S_FNB: begin
        // Release the block, merging with the following free block when adjacent
        cnew_nxt.alloc = 1'b0;
        if (nb_join) begin
          cnew_nxt.size = ZW'(CW'(hc_r.size) + CW'(rd.size));
          cnew_nxt.nxt  = rd.nxt;
        end else begin
          cnew_nxt.size = hc_r.size;
          cnew_nxt.nxt  = hf_r.nxt;
        end
        mem_we    = 1'b1;
        mem_waddr = c_r;
        mem_wdata = cnew_nxt;
        used_nxt  = used_r - 11'(hc_r.size);
        state_nxt = S_FWF;
      end

      S_FWF: begin
        // Merge into the preceding free block or link to it
        mem_we          = 1'b1;
        mem_waddr       = f_r;
        mem_wdata.alloc = hf_r.alloc;
        if (CW'(c_r) == f_end) begin
          mem_wdata.size = ZW'(CW'(hf_r.size) + CW'(cnew_r.size));
          mem_wdata.nxt  = cnew_r.nxt;
        end else begin
          mem_wdata.size = hf_r.size;
          mem_wdata.nxt  = c_r;
        end
        rover_nxt      = f_r;
        res_status_nxt = ST_OK;
        state_nxt      = S_DONE;
      end

      S_DONE: begin
        // Hand the result to the output register when it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt      = 1'b1;
          out_status_nxt     = res_status_r;
          out_address_nxt    = res_addr_r;
          out_free_bytes_nxt = ready_r ? {free_diff[10:0], 3'b000} : 14'd0;
          state_nxt          = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      arena_bytes_r <= 14'd8208;
      span_r        <= '0;
      rover_r       <= '0;
      used_r        <= '0;
      ready_r       <= 1'b0;
      steps_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      arena_bytes_r <= arena_bytes_nxt;
      span_r        <= span_nxt;
      rover_r       <= rover_nxt;
      used_r        <= used_nxt;
      ready_r       <= ready_nxt;
      steps_r       <= steps_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    need_r           <= need_nxt;
    cur_r            <= cur_nxt;
    prev_r           <= prev_nxt;
    prev_rec_r       <= prev_rec_nxt;
    cfin_r           <= cfin_nxt;
    c_r              <= c_nxt;
    hc_r             <= hc_nxt;
    f_r              <= f_nxt;
    hf_r             <= hf_nxt;
    tail_r           <= tail_nxt;
    cnew_r           <= cnew_nxt;
    res_status_r     <= res_status_nxt;
    res_addr_r       <= res_addr_nxt;
    out_status_r     <= out_status_nxt;
    out_address_r    <= out_address_nxt;
    out_free_bytes_r <= out_free_bytes_nxt;
  end

  // Rover always names a block inside the laid-out arena (a re-initialise resets it
  // in the cycle after the new span is taken)
  a_rover_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (ready_r && state_r != S_INIT1) |-> (ZW'(rover_r) < span_r))
    else $error("rover outside arena");

  // An initialised arena holds at least head, one block and sentinel
  a_span_min: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> (span_r >= ZW'(MIN_SPAN)))
    else $error("arena span too small");

  // An accepted request always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("request accepted without work");

  // Header writes only happen in update states
  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_IDLE || state_r == S_INIT1 || state_r == S_AWALK ||
                state_r == S_AWR || state_r == S_FNB || state_r == S_FWF))
    else $error("header write in wrong state");

endmodule

`default_nettype wire

### dv/tb_next_fit_block_allocator.sv
// Self-checking testbench for the next-fit block allocator: predictor, scoreboard and stimulus.
`default_nettype none

module tb_next_fit_block_allocator;
  import nfba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBLK = 1024;
  localparam int unsigned CYCLE_LIMIT = 20000000;

  typedef struct packed {
    status_t     st;
    logic [13:0] addr;
    logic [13:0] fbytes;
  } alloc_result_t;

  // Scoreboard with its own model of the header store and allocator state
  class alloc_scoreboard;
    int unsigned hnext [NBLK];
    int unsigned hsize [NBLK];
    bit          hused [NBLK];
    bit          written [NBLK];
    int unsigned rover, used_blk, span, arena;
    bit          ready;
    alloc_result_t pending[$];
    logic [13:0] live[$];
    logic [13:0] stale[$];
    int          errors, checked, noted;

    function new();
      arena = 8208;
    endfunction

    function void wr(int unsigned i);
      written[i % NBLK] = 1'b1;
    endfunction

    function logic [13:0] free_report();
      if (!ready) return 14'd0;
      return 14'(8 * (span - used_blk - 1));
    endfunction

    function status_t do_init();
      int unsigned s;
      if (arena < MIN_ARENA_BYTES) return ST_NO_SPACE;
      s = (arena - CTRL_BYTES) >> 3;
      if (s > NBLK) s = NBLK;
      span = s;
      hsize[0] = s - 1; hnext[0] = s - 1; hused[0] = 0; wr(0);
      hsize[s-1] = 0; hnext[s-1] = 0; hused[s-1] = 0; wr(s - 1);
      rover = 0;
      used_blk = 0;
      ready = 1;
      return ST_OK;
    endfunction

    function status_t do_alloc(int unsigned n, output logic [13:0] a);
      int unsigned need, prev, cur, steps, rest;
      a = 14'd0;
      need = ((n < SMALL_REQ ? SMALL_ROUND : n + ROUND_ADD) >> 3) + 1;
      prev = rover;
      cur = hnext[rover];
      steps = 0;
      // walk next-fit until a block is large enough or the list wraps
      forever begin
        if (hsize[cur] >= need) break;
        prev = cur;
        if (cur == rover) return ST_NO_SPACE;
        steps++;
        if (steps > NBLK) return ST_NO_SPACE;
        cur = hnext[cur];
      end
      rest = hsize[cur] - need;
      if (rest == 0) begin
        hnext[prev] = hnext[cur]; wr(prev);
      end else begin
        hsize[cur] = rest; wr(cur);
        cur += rest;
        hsize[cur] = need;
      end
      rover = prev;
      hused[cur] = 1; hnext[cur] = 0; wr(cur);
      used_blk += hsize[cur];
      a = 14'(24 + 8 * cur);
      return ST_OK;
    endfunction

    function status_t do_free(int unsigned p);
      int unsigned c, f, f2, nb, steps;
      bit tail_only, adv;
      steps = 0;
      tail_only = 0;
      if (p == 0 || (p & 7) != 0) return ST_BAD_PTR;
      if (p < PAYLOAD_BASE) return ST_RANGE;
      c = (p - PAYLOAD_BASE) >> 3;
      if (c >= span) return ST_RANGE;
      if (!hused[c] || hsize[c] == 0) return ST_BAD_PTR;
      f = rover;
      // find the free block that precedes c in address order
      if (!(f < c && c < hnext[f])) begin
        forever begin
          if (c == f) return ST_OVERLAP;
          steps++;
          if (steps > NBLK + 1) return ST_OVERLAP;
          f2 = hnext[f];
          if (f < f2) adv = 1;
          else if (c < f2) break;
          else adv = (f >= c);
          if (adv) begin
            f = f2;
            if (f2 >= c || c >= hnext[f2]) continue;
          end
          tail_only = (c >= hnext[f]);
          break;
        end
      end
      if (!tail_only && hnext[f] < c + hsize[c]) return ST_OVERLAP;
      if (f < c && c < f + hsize[f]) return ST_OVERLAP;
      used_blk -= hsize[c];
      nb = c + hsize[c];
      hused[c] = 0;
      // merge with the following and the preceding free block
      if (nb != hnext[f] || hsize[nb % NBLK] == 0) begin
        hnext[c] = hnext[f];
      end else begin
        hsize[c] += hsize[nb];
        hnext[c] = hnext[nb];
      end
      wr(c);
      if (c == f + hsize[f]) begin
        hsize[f] += hsize[c];
        hnext[f] = hnext[c];
      end else begin
        hnext[f] = c;
      end
      wr(f);
      rover = f;
      return ST_OK;
    endfunction

    // True when freeing p would read a header that was never written
    function bit reads_unwritten(logic [13:0] p);
      int unsigned c;
      if (!ready || p == 0 || p[2:0] != 0 || p < PAYLOAD_BASE) return 0;
      c = (p - PAYLOAD_BASE) >> 3;
      return (c < span) && !written[c];
    endfunction

    function void note_input(mode_t m, logic [13:0] req, logic [13:0] fa);
      alloc_result_t r;
      logic [13:0] a;
      r.st = ST_OK;
      r.addr = 14'd0;
      noted++;
      case (m)
        MODE_INIT: begin
          r.st = do_init();
          if (r.st == ST_OK) begin
            foreach (live[i]) stale.push_back(live[i]);
            live.delete();
          end
        end
        MODE_ALLOC: begin
          if (!ready) r.st = ST_NOT_INIT;
          else begin
            r.st = do_alloc(req, a);
            r.addr = a;
            if (r.st == ST_OK) live.push_back(a);
          end
        end
        MODE_FREE: begin
          if (!ready) r.st = ST_NOT_INIT;
          else begin
            r.st = do_free(fa);
            if (r.st == ST_OK) begin
              foreach (live[i]) if (live[i] == fa) begin
                live.delete(i);
                break;
              end
              stale.push_back(fa);
            end
          end
        end
        default: ;
      endcase
      if (stale.size() > 64) void'(stale.pop_front());
      r.fbytes = free_report();
      pending.push_back(r);
    endfunction

    function void check_result(logic [2:0] st, logic [13:0] a, logic [13:0] fb);
      alloc_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d address=%0d free_bytes=%0d",
                 $time, st, a, fb);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (st !== e.st) begin
        $display("%0t: status expected %0d actual %0d", $time, e.st, st);
        errors++;
      end
      if (a !== e.addr) begin
        $display("%0t: address expected %0d actual %0d", $time, e.addr, a);
        errors++;
      end
      if (fb !== e.fbytes) begin
        $display("%0t: free_bytes expected %0d actual %0d", $time, e.fbytes, fb);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  mode_t       in_mode = MODE_NONE;
  logic [13:0] in_request_bytes = '0;
  logic [13:0] in_free_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [13:0] out_address;
  logic [13:0] out_free_bytes;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [13:0] cfg_data = '0;

  alloc_scoreboard sb = new();
  int          tx_idle = 0;
  int          rx_idle = 0;
  int unsigned cycles = 0;
  int          cfg_writes = 0;

  next_fit_block_allocator uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_request_bytes(in_request_bytes), .in_free_address(in_free_address),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_address(out_address), .out_free_bytes(out_free_bytes),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the result channel at the current rate
  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= rx_idle);

  // Check each result transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_status, out_address, out_free_bytes);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("next_fit_block_allocator test failed");
      $finish;
    end
  end

  // Present one request and hold it until the transaction completes
  task automatic send_req(mode_t m, logic [13:0] req, logic [13:0] fa);
    if ($urandom_range(0, 99) < tx_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    if (m == MODE_FREE && sb.reads_unwritten(fa)) fa = 14'd0;
    in_mode <= m;
    in_request_bytes <= req;
    in_free_address <= fa;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(m, req, fa);
    @(negedge clk);
  endtask

  // Drain all results and let the sequencer settle
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // Write the arena size while the block is idle
  task automatic write_arena(logic [13:0] v);
    drain();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.arena = v;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [13:0] pick_free_addr();
    int k;
    k = $urandom_range(0, 99);
    if (k < 78 && sb.live.size() != 0) return sb.live[$urandom_range(0, sb.live.size() - 1)];
    if (k < 88 && sb.stale.size() != 0)
      return sb.stale[$urandom_range(0, sb.stale.size() - 1)];
    if (k < 94) return 14'(24 + 8 * $urandom_range(0, 1100));
    return 14'($urandom);
  endfunction

  function automatic logic [13:0] pick_req_bytes();
    int k;
    k = $urandom_range(0, 99);
    if (k < 70) return 14'($urandom_range(0, 160));
    if (k < 92) return 14'($urandom_range(0, 1600));
    return 14'($urandom);
  endfunction

  // One random request, mostly allocate and free of live blocks
  task automatic random_req();
    int k;
    k = $urandom_range(0, 99);
    if (k < 2) send_req(MODE_INIT, 14'($urandom), 14'($urandom));
    else if (k < 4) send_req(MODE_NONE, 14'($urandom), 14'($urandom));
    else if (k < 52 || sb.live.size() == 0)
      send_req(MODE_ALLOC, pick_req_bytes(), 14'($urandom));
    else send_req(MODE_FREE, 14'($urandom), pick_free_addr());
  endtask

  localparam int NPHASE = 7;
  logic [13:0] arena_set [NPHASE] = '{14'd8208, 14'd41, 14'd300, 14'd1000,
                                      14'd16383, 14'd2048, 14'd600};

  initial begin
    logic [13:0] a0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: requests before initialise, unknown mode, odd arena sizes
    send_req(MODE_ALLOC, 14'd16, 14'd0);
    send_req(MODE_FREE, 14'd0, 14'd24);
    send_req(MODE_NONE, 14'h3FFF, 14'h3FFF);
    write_arena(14'd40);
    send_req(MODE_INIT, 14'd0, 14'd0);
    write_arena(14'd0);
    send_req(MODE_INIT, 14'd0, 14'd0);
    write_arena(14'd16383);
    send_req(MODE_INIT, 14'd0, 14'd0);
    send_req(MODE_ALLOC, 14'd0, 14'd0);
    a0 = sb.live[0];
    send_req(MODE_ALLOC, 14'd7, 14'd0);
    send_req(MODE_ALLOC, 14'd8, 14'd0);
    send_req(MODE_ALLOC, 14'd8208, 14'd0);
    send_req(MODE_ALLOC, 14'h3FFF, 14'd0);
    send_req(MODE_FREE, 14'd0, 14'd0);
    send_req(MODE_FREE, 14'd0, 14'd25);
    send_req(MODE_FREE, 14'd0, 14'd16);
    send_req(MODE_FREE, 14'd0, 14'd16376);
    send_req(MODE_FREE, 14'd0, a0);
    send_req(MODE_FREE, 14'd0, a0);
    send_req(MODE_FREE, 14'd0, 14'd24);
    send_req(MODE_INIT, 14'd0, 14'd0);
    send_req(MODE_FREE, 14'd0, sb.stale[sb.stale.size() - 1]);
    write_arena(14'd41);
    send_req(MODE_INIT, 14'd0, 14'd0);
    send_req(MODE_ALLOC, 14'd0, 14'd0);

    // Random phases over arena sizes and idle rates
    for (int ph = 0; ph < NPHASE; ph++) begin
      case (ph % 3)
        0: begin tx_idle = 10; rx_idle = 68; end
        1: begin tx_idle = 68; rx_idle = 10; end
        default: begin tx_idle = 0; rx_idle = 0; end
      endcase
      write_arena(arena_set[ph]);
      send_req(MODE_INIT, 14'd0, 14'd0);
      for (int i = 0; i < 107; i++) begin
        if (i == 50) drain();
        random_req();
      end
    end

    // Drain and settle
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
      sb.errors++;
    end
    $display("Covered %0d requests and %0d checked results over %0d arena size writes,",
             sb.noted, sb.checked, cfg_writes);
    $display("with allocate, free, initialise and unknown mode under three stall patterns.");
    if (sb.errors == 0) begin
      $display("next_fit_block_allocator test passed");
    end else begin
      $display("next_fit_block_allocator test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
hdl/nfba_pkg.sv
hdl/nfba_hdr_mem.sv
hdl/next_fit_block_allocator.sv
dv/tb_next_fit_block_allocator.sv
